// File: hw/rtl/swtm_pkg.sv
// Shared constants, types and state codes for the trimmed-mean normalizer.
package swtm_pkg;

	// Window and field geometry
	localparam int WINDOW    = 20;
	localparam int NUM_CH    = 5;
	localparam int SAMPLE_W  = 8;
	localparam int CH_W      = 3;
	localparam int SCALE_W   = 8;
	localparam int CFG_IDX_W = 3;

	// Selection by repeated maximum extraction
	localparam int MID       = WINDOW / 2;
	localparam int NPASS     = WINDOW - MID + 2;
	localparam int KEEP_FROM = WINDOW - MID - 1;
	localparam int CYC_W     = $clog2(WINDOW);
	localparam int PASS_W    = $clog2(NPASS);
	localparam int SUM_W     = SAMPLE_W + 2;

	// Divide by three as multiply by reciprocal, exact for sums below 2047
	localparam int RECIP3    = 683;
	localparam int RECIP3_SH = 11;
	localparam int PROD_W    = 2 * SUM_W;

	// Scaling to percent of full scale
	localparam int LEVEL_GAIN = 100;
	localparam int DIVD_W     = SAMPLE_W + 7;
	localparam int DIVCNT_W   = $clog2(DIVD_W);

	localparam logic [SAMPLE_W-1:0] LEVEL_MAX = '1;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_SORT,
		ST_MEAN,
		ST_SCALE,
		ST_DIV,
		ST_OUT
	} swtm_state_t;

	typedef struct packed {
		logic                load;
		logic                start;
		logic [SAMPLE_W-1:0] data;
	} swtm_sort_ctl_t;

	typedef struct packed {
		logic               start;
		logic [DIVD_W-1:0]  dividend;
		logic [SCALE_W-1:0] divisor;
	} swtm_div_ctl_t;

endpackage

// File: hw/rtl/swtm_sorter.sv
// Sample ring with one shared compare/swap unit that picks the middle three values.
module swtm_sorter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swtm_pkg::swtm_sort_ctl_t        ctl,
	output logic                            done,
	output logic [swtm_pkg::SUM_W-1:0]      sum
);
	import swtm_pkg::*;

	logic [SAMPLE_W-1:0] ring_q [WINDOW];
	logic [SAMPLE_W-1:0] carry_q;
	logic [CYC_W-1:0]    cyc_q;
	logic [PASS_W-1:0]   pass_q;
	logic [SUM_W-1:0]    sum_q;
	logic                busy_q;
	logic                done_q;

	logic [SAMPLE_W-1:0] head;
	logic [SAMPLE_W-1:0] big;
	logic [SAMPLE_W-1:0] small_val;
	logic                head_gt;
	logic                pass_end;
	logic                last_pass;
	logic                keep;

	// Compare the ring head against the running maximum
	always_comb begin
		head      = ring_q[0];
		head_gt   = head > carry_q;
		big       = head_gt ? head : carry_q;
		small_val = head_gt ? carry_q : head;
		pass_end  = cyc_q == CYC_W'(WINDOW - 1);
		last_pass = pass_q == PASS_W'(NPASS - 1);
		keep      = pass_q >= PASS_W'(KEEP_FROM);
	end

	// Rotate the ring: new samples while loading, the smaller value while sorting
	always_ff @(posedge clk) begin
		if (ctl.load || busy_q) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				ring_q[i] <= ring_q[i + 1];
			end
			ring_q[WINDOW - 1] <= busy_q ? small_val : ctl.data;
		end
	end

	// Pass sequencer: each pass pulls out the largest remaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cyc_q   <= '0;
			pass_q  <= '0;
			sum_q   <= '0;
			carry_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q  <= 1'b1;
				cyc_q   <= '0;
				pass_q  <= '0;
				sum_q   <= '0;
				carry_q <= '0;
			end else if (busy_q) begin
				if (pass_end) begin
					// Drop a zero into the ring in place of the extracted maximum
					carry_q <= '0;
					cyc_q   <= '0;
					if (keep) begin
						sum_q <= sum_q + SUM_W'(big);
					end
					if (last_pass) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						pass_q <= pass_q + 1'b1;
					end
				end else begin
					carry_q <= big;
					cyc_q   <= cyc_q + 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign sum  = sum_q;

endmodule

// File: hw/rtl/swtm_divider.sv
// Restoring divider, one quotient bit per cycle.
module swtm_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  swtm_pkg::swtm_div_ctl_t          ctl,
	output logic                             done,
	output logic [swtm_pkg::DIVD_W-1:0]      quotient
);
	import swtm_pkg::*;

	logic [SCALE_W-1:0]  rem_q;
	logic [SCALE_W-1:0]  div_q;
	logic [DIVD_W-1:0]   quo_q;
	logic [DIVCNT_W-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [SCALE_W:0]    trial;
	logic [SCALE_W:0]    diff;
	logic                fits;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				div_q  <= ctl.divisor;
				quo_q  <= ctl.dividend;
			end else if (busy_q) begin
				rem_q <= fits ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], fits};
				if (cnt_q == DIVCNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/sorted_window_trimmed_mean_normalizer.sv
// Top level: window fill, sequencer, scale registers and output register.
//
// Usage:
//   Samples enter on the s_axis channel, one per cycle while s_axis_tready is
//   high; the channel of the first sample of a window sets the window's
//   channel. After WINDOW (20) samples the block drops s_axis_tready and
//   selects the three middle sorted values with one compare unit over a ring
//   of registers, in NPASS (12) passes. Two multiplies form the mean (divide
//   by three) and 100 x mean, then a setup state and the bit-serial divider
//   give the level (the divider is skipped when the scale is zero).
//   s_axis_tready stays low until the result moves into the output register.
//   Results leave on m_axis from an output register. A stalled receiver holds
//   the result; the next window fills meanwhile and waits for the register
//   only when its own result is ready.
//   The cfg channel is always ready; cfg_index 0..4 selects a scale register,
//   other indexes are ignored. Write it only while the block is idle.
//   Reset clears the window fill, sets every scale to 255 and empties the
//   output register.
module sorted_window_trimmed_mean_normalizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] sample
	input  logic [2:0]  s_axis_tuser,   // [2:0] channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] level, [15:8] trimmed_mean, [16] saturated
	output logic [2:0]  m_axis_tuser,   // [2:0] out_channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import swtm_pkg::*;

	swtm_state_t         state_q, state_d;
	swtm_sort_ctl_t      sort_ctl;
	swtm_div_ctl_t       div_ctl;

	logic [SCALE_W-1:0]  scale_q [NUM_CH];
	logic [CYC_W-1:0]    fill_q;
	logic [CH_W-1:0]     win_ch_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [DIVD_W-1:0]   dividend_q;
	logic [SAMPLE_W-1:0] res_level_q;
	logic                res_sat_q;

	logic                m_valid_q;
	logic [SAMPLE_W-1:0] out_level_q;
	logic [SAMPLE_W-1:0] out_mean_q;
	logic                out_sat_q;
	logic [CH_W-1:0]     out_ch_q;

	logic                in_acc;
	logic                last_sample;
	logic                sort_done;
	logic [SUM_W-1:0]    sort_sum;
	logic                div_done;
	logic [DIVD_W-1:0]   div_quo;
	logic [SAMPLE_W-1:0] mean_c;
	logic [SCALE_W-1:0]  win_scale;
	logic                out_free;

	swtm_sorter u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sort_ctl),
		.done   (sort_done),
		.sum    (sort_sum)
	);

	swtm_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Handshake and datapath helpers
	always_comb begin
		s_axis_tready = state_q == ST_FILL;
		cfg_ready     = 1'b1;
		in_acc        = s_axis_tvalid && s_axis_tready;
		last_sample   = fill_q == CYC_W'(WINDOW - 1);
		mean_c        = prod_q[RECIP3_SH +: SAMPLE_W];
		win_scale     = (win_ch_q < CH_W'(NUM_CH)) ? scale_q[win_ch_q] : '0;
		out_free      = !m_valid_q || m_axis_tready;
	end

	// Sequencer: next state and unit commands
	always_comb begin
		state_d           = state_q;
		sort_ctl.load     = in_acc;
		sort_ctl.start    = 1'b0;
		sort_ctl.data     = s_axis_tdata;
		div_ctl.start     = 1'b0;
		div_ctl.dividend  = dividend_q;
		div_ctl.divisor   = win_scale;
		case (state_q)
			ST_FILL: begin
				if (in_acc && last_sample) begin
					sort_ctl.start = 1'b1;
					state_d        = ST_SORT;
				end
			end
			ST_SORT: begin
				if (sort_done) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if (win_scale == '0) begin
					state_d = ST_OUT;
				end else begin
					div_ctl.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Scale registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				scale_q[i] <= '1;
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_CH))) begin
			scale_q[cfg_index] <= cfg_data;
		end
	end

	// Window fill count and window channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			win_ch_q <= '0;
		end else if (in_acc) begin
			if (fill_q == '0) begin
				win_ch_q <= s_axis_tuser;
			end
			fill_q <= last_sample ? '0 : fill_q + 1'b1;
		end
	end

	// Mean, scaled dividend and level
	always_ff @(posedge clk) begin
		if (state_q == ST_SORT && sort_done) begin
			prod_q <= PROD_W'(sort_sum) * PROD_W'(RECIP3);
		end
		if (state_q == ST_MEAN) begin
			mean_q     <= mean_c;
			dividend_q <= DIVD_W'(mean_c) * DIVD_W'(LEVEL_GAIN);
		end
		if (state_q == ST_SCALE && win_scale == '0) begin
			res_level_q <= LEVEL_MAX;
			res_sat_q   <= 1'b1;
		end
		if (state_q == ST_DIV && div_done) begin
			if (div_quo[DIVD_W-1:SAMPLE_W] != '0) begin
				res_level_q <= LEVEL_MAX;
				res_sat_q   <= 1'b1;
			end else begin
				res_level_q <= div_quo[SAMPLE_W-1:0];
				res_sat_q   <= 1'b0;
			end
		end
	end

	// Output register: load a finished result, hold it while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_level_q <= res_level_q;
			out_mean_q  <= mean_q;
			out_sat_q   <= res_sat_q;
			out_ch_q    <= win_ch_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, out_sat_q, out_mean_q, out_level_q};
	assign m_axis_tuser  = out_ch_q;

endmodule

// File: test/tb_sorted_window_trimmed_mean_normalizer.sv
`timescale 1ns / 1ps
// Self-checking bench for the trimmed-mean normalizer: predicts every window result and compares.
module tb_sorted_window_trimmed_mean_normalizer;
	import swtm_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 320;
	localparam int HOLD_CYCLES  = 3000;

	typedef struct packed {
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] level;
		logic [SAMPLE_W-1:0] mean;
		logic                sat;
	} level_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	typedef enum logic [2:0] {
		WIN_RANDOM,
		WIN_FLAT,
		WIN_NARROW,
		WIN_LOW,
		WIN_EXTREME
	} win_kind_t;

	typedef enum logic [2:0] {
		SCALE_FULL,
		SCALE_ZERO,
		SCALE_ONE,
		SCALE_RANDOM,
		SCALE_MIXED
	} scale_setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// Predictor state
	logic [SAMPLE_W-1:0] window_buf [WINDOW];
	logic [SCALE_W-1:0]  scale_regs [NUM_CH];
	int                  fill_count = 0;
	logic [CH_W-1:0]     window_channel = '0;
	level_result_t       pending_levels [$];

	int       mismatches = 0;
	int       cycles = 0;
	int       burst_left = 0;
	int       hold_token = 0;
	int       hold_taken = 0;
	int       hold_left = 0;
	int       rx_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	logic [7:0] rx_pattern = 8'h01;
	level_result_t want;

	sorted_window_trimmed_mean_normalizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: long hold-off on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_taken != hold_token) begin
			hold_taken <= hold_token;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(3));
				rx_left <= $urandom_range(400, 20);
				rx_pattern <= 8'($urandom) | 8'h01;
			end else begin
				rx_left <= rx_left - 1;
				rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
			end
			case (rx_mode)
				RX_OPEN:    m_axis_tready <= 1'b1;
				RX_COIN:    m_axis_tready <= 1'($urandom_range(1));
				RX_PATTERN: m_axis_tready <= rx_pattern[0];
				default:    m_axis_tready <= ($urandom_range(7) == 0);
			endcase
		end
	end

	task automatic note_mismatch(input string what, input int w, input int g);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %0d, got %0d", what, w, g);
	endtask

	// Compare each result item with the oldest prediction
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_levels.size() == 0) begin
				note_mismatch("unexpected result", 0, m_axis_tdata);
			end else begin
				want = pending_levels.pop_front();
				if (m_axis_tuser !== want.ch)
					note_mismatch("out_channel", want.ch, m_axis_tuser);
				if (m_axis_tdata[7:0] !== want.level)
					note_mismatch("level", want.level, m_axis_tdata[7:0]);
				if (m_axis_tdata[15:8] !== want.mean)
					note_mismatch("trimmed_mean", want.mean, m_axis_tdata[15:8]);
				if (m_axis_tdata[16] !== want.sat)
					note_mismatch("saturated", want.sat, m_axis_tdata[16]);
				if (m_axis_tdata[23:17] !== '0)
					note_mismatch("tdata padding", 0, m_axis_tdata[23:17]);
			end
		end
	end

	// Collect one sample; on a full window sort, average the middle three and scale
	task automatic accept_sample(input logic [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch);
		logic [SAMPLE_W-1:0] sorted_win [WINDOW];
		logic [SAMPLE_W-1:0] t;
		int i;
		int j;
		int unsigned mean;
		int unsigned scale;
		int unsigned q;
		level_result_t r;
		if (fill_count == 0)
			window_channel = ch;
		window_buf[fill_count] = smp;
		fill_count++;
		if (fill_count == WINDOW) begin
			fill_count = 0;
			sorted_win = window_buf;
			for (i = 0; i < WINDOW - 1; i++) begin
				for (j = 0; j < WINDOW - 1 - i; j++) begin
					if (sorted_win[j] > sorted_win[j + 1]) begin
						t = sorted_win[j];
						sorted_win[j] = sorted_win[j + 1];
						sorted_win[j + 1] = t;
					end
				end
			end
			mean = (int'(sorted_win[MID - 2]) + int'(sorted_win[MID - 1])
				+ int'(sorted_win[MID])) / 3;
			scale = (window_channel < NUM_CH) ? scale_regs[window_channel] : 0;
			r.ch = window_channel;
			r.mean = mean[SAMPLE_W-1:0];
			if (scale == 0) begin
				r.level = LEVEL_MAX;
				r.sat = 1'b1;
			end else begin
				q = (LEVEL_GAIN * mean) / scale;
				r.sat = (q > int'(LEVEL_MAX));
				r.level = r.sat ? LEVEL_MAX : q[SAMPLE_W-1:0];
			end
			pending_levels.push_back(r);
		end
	endtask

	// Offer one item in bursts with random gaps; valid stays up between items
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(25, 1);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tuser <= ch;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		accept_sample(smp, ch);
	endtask

	task automatic stop_sending;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	// Send a full window; only the first item carries the window channel
	task automatic send_window(input logic [CH_W-1:0] ch, input win_kind_t kind);
		logic [SAMPLE_W-1:0] base;
		logic [SAMPLE_W-1:0] smp;
		int i;
		base = 8'($urandom);
		for (i = 0; i < WINDOW; i++) begin
			case (kind)
				WIN_RANDOM:  smp = 8'($urandom);
				WIN_FLAT:    smp = base;
				WIN_NARROW:  smp = base + 8'($urandom_range(6));
				WIN_LOW:     smp = 8'($urandom_range(12));
				default:     smp = $urandom_range(1) ? LEVEL_MAX : '0;
			endcase
			send_sample(smp, (i == 0) ? ch : 3'($urandom));
		end
	endtask

	// Write all five scales, then the unused indexes, which must change nothing
	task automatic program_scales(input scale_setting_t how);
		logic [SCALE_W-1:0] val;
		int i;
		for (i = 0; i < 8; i++) begin
			case (how)
				SCALE_FULL:   val = LEVEL_MAX;
				SCALE_ZERO:   val = '0;
				SCALE_ONE:    val = 8'd1;
				SCALE_RANDOM: val = 8'($urandom);
				default: begin
					case ($urandom_range(3))
						0:       val = '0;
						1:       val = 8'd1;
						2:       val = LEVEL_MAX;
						default: val = 8'($urandom);
					endcase
				end
			endcase
			if (i >= NUM_CH)
				val = 8'($urandom);
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (i < NUM_CH)
				scale_regs[i] = val;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_results_drained;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reset scales, extreme samples, zero scale, unlisted channel codes
	task automatic test_directed_windows;
		send_window(3'd2, WIN_EXTREME);
		stop_sending();
		wait_results_drained();
		program_scales(SCALE_ZERO);
		send_window(3'd0, WIN_EXTREME);
		send_window(3'd5, WIN_RANDOM);
		stop_sending();
	endtask

	// Several scale settings, each followed by windows of mixed shapes
	task automatic test_random_phases;
		int p;
		int w;
		for (p = 0; p < 6; p++) begin
			wait_results_drained();
			case (p)
				0:       program_scales(SCALE_FULL);
				1:       program_scales(SCALE_ONE);
				2:       program_scales(SCALE_ZERO);
				3:       program_scales(SCALE_RANDOM);
				default: program_scales(SCALE_MIXED);
			endcase
			for (w = 0; w < 4; w++)
				send_window(($urandom_range(7) == 0) ? 3'($urandom_range(7, 5))
					: 3'($urandom_range(4)), win_kind_t'($urandom_range(4)));
			repeat ($urandom_range(7)) send_sample(8'($urandom), 3'($urandom));
			stop_sending();
		end
	endtask

	// Stall the receiver long enough that the block backs up into its input
	task automatic test_receiver_holdoff;
		wait_results_drained();
		program_scales(SCALE_MIXED);
		hold_token++;
		repeat (3) send_window(3'($urandom_range(4)), win_kind_t'($urandom_range(4)));
		stop_sending();
	endtask

	// Pause mid-window until all results are in, then finish the window
	task automatic test_pause_until_drained;
		repeat (30) send_sample(8'($urandom), 3'($urandom));
		stop_sending();
		wait_results_drained();
		repeat (30) send_sample(8'($urandom), 3'($urandom));
		stop_sending();
	endtask

	initial begin
		for (int i = 0; i < NUM_CH; i++)
			scale_regs[i] = LEVEL_MAX;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_windows();
		test_random_phases();
		test_receiver_holdoff();
		test_pause_until_drained();
		wait_results_drained();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
